>>> design/edge_outward_unit_normal_defines.svh
// Assertion helpers shared by the design files.
`ifndef EDGE_OUTWARD_UNIT_NORMAL_DEFINES_SVH
`define EDGE_OUTWARD_UNIT_NORMAL_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define EOUN_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent in the same cycle.
`define EOUN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent in the next cycle.
`define EOUN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/eoun_pkg.sv
`default_nettype none

package eoun_pkg;

  // Fraction bits of the unit normal
  localparam int NormFracBits = 16;
  localparam int NormW        = 18;

  // Edge and centroid widths
  localparam int DeltaW = 33;
  localparam int GapW   = 35;
  localparam int SqW    = 65;
  localparam int SumW   = 66;
  localparam int MagW   = 68;

  // Divider and root pipeline depths
  localparam int DivSteps  = 2 * NormFracBits + 3;
  localparam int RootBits  = NormFracBits + 2;
  localparam int LineDepth = DivSteps + RootBits;

  // Front queue
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  typedef enum logic [1:0] {
    StatComputed   = 2'd0,
    StatSkipped    = 2'd1,
    StatDegenerate = 2'd2
  } status_e;

  typedef struct packed {
    status_e           status;
    logic              last;
    logic [DeltaW-1:0] dx;
    logic [DeltaW-1:0] dy;
    logic [GapW-1:0]   gx;
    logic [GapW-1:0]   gy;
  } edge_item_t;

  typedef struct packed {
    status_e status;
    logic    last;
    logic    flip;
    logic    dy_neg;
    logic    dx_pos;
  } side_t;

endpackage

`default_nettype wire

>>> design/eoun_front.sv
`default_nettype none

`include "edge_outward_unit_normal_defines.svh"

module eoun_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic               on_boundary_i,
  input  wire logic               last_edge_i,
  input  wire logic signed [31:0] first_x_i,
  input  wire logic signed [31:0] first_y_i,
  input  wire logic signed [31:0] second_x_i,
  input  wire logic signed [31:0] second_y_i,
  input  wire logic signed [31:0] tri_a_x_i,
  input  wire logic signed [31:0] tri_a_y_i,
  input  wire logic signed [31:0] tri_b_x_i,
  input  wire logic signed [31:0] tri_b_y_i,
  input  wire logic signed [31:0] tri_c_x_i,
  input  wire logic signed [31:0] tri_c_y_i,
  output eoun_pkg::edge_item_t    head_o,
  output logic                    head_valid_o,
  input  wire logic               head_pop_i
);

  eoun_pkg::edge_item_t item;
  logic signed [eoun_pkg::DeltaW-1:0] dx, dy;
  logic signed [eoun_pkg::GapW-1:0]   gx, gy;

  eoun_pkg::edge_item_t            mem_q [eoun_pkg::QueueDepth];
  logic [eoun_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [eoun_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            wr_en, rd_en;

  // Form edge vector and centroid offset times three
  always_comb begin
    dx = eoun_pkg::DeltaW'(second_x_i) - eoun_pkg::DeltaW'(first_x_i);
    dy = eoun_pkg::DeltaW'(second_y_i) - eoun_pkg::DeltaW'(first_y_i);
    gx = eoun_pkg::GapW'(tri_a_x_i) + eoun_pkg::GapW'(tri_b_x_i) + eoun_pkg::GapW'(tri_c_x_i)
         - eoun_pkg::GapW'(first_x_i) - eoun_pkg::GapW'(first_x_i)
         - eoun_pkg::GapW'(first_x_i);
    gy = eoun_pkg::GapW'(tri_a_y_i) + eoun_pkg::GapW'(tri_b_y_i) + eoun_pkg::GapW'(tri_c_y_i)
         - eoun_pkg::GapW'(first_y_i) - eoun_pkg::GapW'(first_y_i)
         - eoun_pkg::GapW'(first_y_i);
  end

  // Classify the request
  always_comb begin
    item.last = last_edge_i;
    item.dx   = dx;
    item.dy   = dy;
    item.gx   = gx;
    item.gy   = gy;
    if (!on_boundary_i) begin
      item.status = eoun_pkg::StatSkipped;
    end else if (dx == '0 && dy == '0) begin
      item.status = eoun_pkg::StatDegenerate;
    end else begin
      item.status = eoun_pkg::StatComputed;
    end
  end

  assign full_o       = (cnt_q == eoun_pkg::QCntW'(eoun_pkg::QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = head_pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  `EOUN_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= eoun_pkg::QCntW'(eoun_pkg::QueueDepth), "queue count over depth")
  `EOUN_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, full_o && !head_pop_i, full_o, "full dropped without a pop")

endmodule

`default_nettype wire

>>> design/eoun_div.sv
`default_nettype none

module eoun_div (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [eoun_pkg::SqW-1:0]      num_i,
  input  wire logic [eoun_pkg::SumW-1:0]     den_i,
  output logic      [eoun_pkg::DivSteps-1:0] quo_o
);

  // Quotient of num * 4^(F+1) by den, one bit per stage
  logic [eoun_pkg::SumW-1:0]     rem_q [eoun_pkg::DivSteps];
  logic [eoun_pkg::SumW-1:0]     den_q [eoun_pkg::DivSteps];
  logic [eoun_pkg::DivSteps-1:0] quo_q [eoun_pkg::DivSteps];

  for (genvar k = 0; k < eoun_pkg::DivSteps; k++) begin : g_step
    logic [eoun_pkg::SumW-1:0]     rem_in, den_in, rem_out;
    logic [eoun_pkg::DivSteps-1:0] quo_in;
    logic                          bit_in, ge;
    logic [eoun_pkg::SumW:0]       trial, diff;

    if (k == 0) begin : g_first
      assign rem_in = eoun_pkg::SumW'(num_i >> 1);
      assign bit_in = num_i[0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign bit_in = 1'b0;
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Compare and subtract
    always_comb begin
      trial   = {rem_in, bit_in};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_out = ge ? diff[eoun_pkg::SumW-1:0] : trial[eoun_pkg::SumW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_out;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[eoun_pkg::DivSteps-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[eoun_pkg::DivSteps-1];

endmodule

`default_nettype wire

>>> design/eoun_isqrt.sv
`default_nettype none

module eoun_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [eoun_pkg::DivSteps-1:0] rad_i,
  output logic      [eoun_pkg::RootBits-1:0] root_o
);

  localparam int SqBits = 2 * eoun_pkg::RootBits;

  // Integer square root, one result bit per stage
  logic [eoun_pkg::RootBits-1:0] root_q [eoun_pkg::RootBits];
  logic [SqBits-1:0]             rad_q  [eoun_pkg::RootBits];

  for (genvar i = 0; i < eoun_pkg::RootBits; i++) begin : g_step
    localparam int B = eoun_pkg::RootBits - 1 - i;
    logic [eoun_pkg::RootBits-1:0] root_in, trial;
    logic [SqBits-1:0]             rad_in, sq;

    if (i == 0) begin : g_first
      assign root_in = '0;
      assign rad_in  = SqBits'(rad_i);
    end else begin : g_rest
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // Keep the trial bit when its square fits
    always_comb begin
      trial = root_in | (eoun_pkg::RootBits'(1) << B);
      sq    = SqBits'(trial) * SqBits'(trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= (sq <= rad_in) ? trial : root_in;
        rad_q[i]  <= rad_in;
      end
    end
  end

  assign root_o = root_q[eoun_pkg::RootBits-1];

endmodule

`default_nettype wire

>>> design/eoun_back.sv
`default_nettype none

`include "edge_outward_unit_normal_defines.svh"

module eoun_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire eoun_pkg::edge_item_t head_i,
  input  wire logic                 head_valid_i,
  output logic                      head_pop_o,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output logic signed [17:0]        normal_x_o,
  output logic signed [17:0]        normal_y_o,
  output logic [1:0]                status_o,
  output logic                      was_flipped_o,
  output logic                      batch_end_o
);

  localparam int L = eoun_pkg::LineDepth;

  logic en;
  logic out_valid_q;

  // Stage one: magnitudes, squares and partial products
  logic [eoun_pkg::DeltaW-1:0] adx, ady;
  logic [eoun_pkg::GapW-1:0]   agx, agy;
  logic                        v1_q;
  eoun_pkg::side_t             sd1_q;
  logic [eoun_pkg::SqW-1:0]    sqx_q, sqy_q;
  logic [63:0]                 pll1_q, pll2_q;
  logic [34:0]                 phm1_q, phm2_q;
  logic [31:0]                 plk1_q, plk2_q;
  logic [2:0]                  hk1_q, hk2_q;
  logic                        neg1_q, neg2_q;

  // Stage two: sum of squares and product magnitudes
  logic                        v2_q;
  eoun_pkg::side_t             sd2_q;
  logic [eoun_pkg::SqW-1:0]    a2x_q, a2y_q;
  logic [eoun_pkg::SumW-1:0]   sum_q;
  logic [eoun_pkg::MagW-1:0]   mag1_q, mag2_q;
  logic                        n1_q, n2_q;

  logic signed [eoun_pkg::MagW:0] p1, p2;
  eoun_pkg::side_t                sd_line_in;

  logic                    line_v_q  [L];
  eoun_pkg::side_t         line_sd_q [L];

  logic [eoun_pkg::DivSteps-1:0] quo_x, quo_y;
  logic [eoun_pkg::RootBits-1:0] root_x, root_y;
  logic [eoun_pkg::RootBits:0]   half_x, half_y;
  logic signed [eoun_pkg::NormW-1:0] qx, qy, nx, ny;
  eoun_pkg::side_t               sd_last;

  logic signed [17:0] normal_x_q, normal_y_q;
  eoun_pkg::status_e  status_q;
  logic               flip_q, last_q;

  assign en         = !out_valid_q || pop_i;
  assign head_pop_o = en && head_valid_i;

  always_comb begin
    adx = head_i.dx[eoun_pkg::DeltaW-1] ? (~head_i.dx + 1'b1) : head_i.dx;
    ady = head_i.dy[eoun_pkg::DeltaW-1] ? (~head_i.dy + 1'b1) : head_i.dy;
    agx = head_i.gx[eoun_pkg::GapW-1] ? (~head_i.gx + 1'b1) : head_i.gx;
    agy = head_i.gy[eoun_pkg::GapW-1] ? (~head_i.gy + 1'b1) : head_i.gy;
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < L; i++) begin
        line_v_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q        <= head_valid_i;
      v2_q        <= v1_q;
      line_v_q[0] <= v2_q;
      for (int i = 1; i < L; i++) begin
        line_v_q[i] <= line_v_q[i-1];
      end
      out_valid_q <= line_v_q[L-1];
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd1_q.status <= head_i.status;
      sd1_q.last   <= head_i.last;
      sd1_q.flip   <= 1'b0;
      sd1_q.dy_neg <= head_i.dy[eoun_pkg::DeltaW-1];
      sd1_q.dx_pos <= !head_i.dx[eoun_pkg::DeltaW-1] && (head_i.dx != '0);
      sqx_q  <= adx[32] ? (eoun_pkg::SqW'(1) << 64)
                        : eoun_pkg::SqW'(64'(adx[31:0]) * 64'(adx[31:0]));
      sqy_q  <= ady[32] ? (eoun_pkg::SqW'(1) << 64)
                        : eoun_pkg::SqW'(64'(ady[31:0]) * 64'(ady[31:0]));
      pll1_q <= 64'(agx[31:0]) * 64'(ady[31:0]);
      phm1_q <= 35'(agx[34:32]) * 35'(ady[31:0]);
      plk1_q <= ady[32] ? agx[31:0] : 32'd0;
      hk1_q  <= agx[34:32] & {3{ady[32]}};
      neg1_q <= head_i.gx[eoun_pkg::GapW-1] ^ head_i.dy[eoun_pkg::DeltaW-1];
      pll2_q <= 64'(agy[31:0]) * 64'(adx[31:0]);
      phm2_q <= 35'(agy[34:32]) * 35'(adx[31:0]);
      plk2_q <= adx[32] ? agy[31:0] : 32'd0;
      hk2_q  <= agy[34:32] & {3{adx[32]}};
      neg2_q <= head_i.gy[eoun_pkg::GapW-1] ^ head_i.dx[eoun_pkg::DeltaW-1];
    end
  end

  // Stage two payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q  <= sd1_q;
      a2x_q  <= sqx_q;
      a2y_q  <= sqy_q;
      sum_q  <= eoun_pkg::SumW'(sqx_q) + eoun_pkg::SumW'(sqy_q);
      mag1_q <= eoun_pkg::MagW'(pll1_q) + (eoun_pkg::MagW'(phm1_q) << 32)
                + (eoun_pkg::MagW'(plk1_q) << 32) + (eoun_pkg::MagW'(hk1_q) << 64);
      mag2_q <= eoun_pkg::MagW'(pll2_q) + (eoun_pkg::MagW'(phm2_q) << 32)
                + (eoun_pkg::MagW'(plk2_q) << 32) + (eoun_pkg::MagW'(hk2_q) << 64);
      n1_q   <= neg1_q;
      n2_q   <= neg2_q;
    end
  end

  // Side test: flip when the centroid lies on the positive side
  always_comb begin
    p1 = n1_q ? -$signed({1'b0, mag1_q}) : $signed({1'b0, mag1_q});
    p2 = n2_q ? -$signed({1'b0, mag2_q}) : $signed({1'b0, mag2_q});
    sd_line_in      = sd2_q;
    sd_line_in.flip = (p1 > p2);
  end

  // Carry side data alongside the divide and root
  always_ff @(posedge clk_i) begin
    if (en) begin
      line_sd_q[0] <= sd_line_in;
      for (int i = 1; i < L; i++) begin
        line_sd_q[i] <= line_sd_q[i-1];
      end
    end
  end

  // The x component comes from |dy|, the y component from |dx|
  eoun_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (a2y_q),
    .den_i (sum_q),
    .quo_o (quo_x)
  );

  eoun_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (a2x_q),
    .den_i (sum_q),
    .quo_o (quo_y)
  );

  eoun_isqrt u_sqrt_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (quo_x),
    .root_o (root_x)
  );

  eoun_isqrt u_sqrt_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (quo_y),
    .root_o (root_y)
  );

  // Round half away, apply signs and drop non-computed edges
  always_comb begin
    sd_last = line_sd_q[L-1];
    half_x  = ({1'b0, root_x} + 1'b1) >> 1;
    half_y  = ({1'b0, root_y} + 1'b1) >> 1;
    qx      = eoun_pkg::NormW'(half_x);
    qy      = eoun_pkg::NormW'(half_y);
    nx      = sd_last.dy_neg ? -qx : qx;
    ny      = sd_last.dx_pos ? -qy : qy;
    if (sd_last.flip) begin
      nx = -nx;
      ny = -ny;
    end
    if (sd_last.status != eoun_pkg::StatComputed) begin
      nx = '0;
      ny = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      normal_x_q <= nx;
      normal_y_q <= ny;
      status_q   <= sd_last.status;
      flip_q     <= sd_last.flip && (sd_last.status == eoun_pkg::StatComputed);
      last_q     <= sd_last.last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign normal_x_o    = normal_x_q;
  assign normal_y_o    = normal_y_q;
  assign status_o      = status_q;
  assign was_flipped_o = flip_q;
  assign batch_end_o   = last_q;

  `EOUN_ASSERT_IMP(a_zero_when_not_computed, clk_i, rst_ni, out_valid_q && status_q != eoun_pkg::StatComputed, normal_x_q == '0 && normal_y_q == '0 && !flip_q, "non-computed edge carries a normal")
  `EOUN_ASSERT_NEXT(a_stall_freezes_line, clk_i, rst_ni, out_valid_q && !pop_i, v2_q == $past(v2_q) && line_v_q[L-1] == $past(line_v_q[L-1]), "pipeline moved while output held")

endmodule

`default_nettype wire

>>> design/edge_outward_unit_normal.sv
// Channel   Direction  Handshake           Payload
// edge      in         push / full         on_boundary, last_edge, node and vertex coords
// normal    out        pop / empty         normal_x, normal_y, status, was_flipped, batch_end
//
// One edge is taken per cycle while results are popped; each passes stage one, stage two,
// the bit-per-stage divider (2F+3 stages) and root (F+2 stages) pipelines and the output register.
// Reset clears the queue, the valid bits and the output flag; no clearing pass.
// A result left waiting freezes the back pipeline; the two-entry front queue keeps
// taking edges until it fills, then full rises.
`default_nettype none

module edge_outward_unit_normal (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               on_boundary_i,
  input  wire logic               last_edge_i,
  input  wire logic signed [31:0] first_x_i,
  input  wire logic signed [31:0] first_y_i,
  input  wire logic signed [31:0] second_x_i,
  input  wire logic signed [31:0] second_y_i,
  input  wire logic signed [31:0] tri_a_x_i,
  input  wire logic signed [31:0] tri_a_y_i,
  input  wire logic signed [31:0] tri_b_x_i,
  input  wire logic signed [31:0] tri_b_y_i,
  input  wire logic signed [31:0] tri_c_x_i,
  input  wire logic signed [31:0] tri_c_y_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [17:0]      normal_x_o,
  output logic signed [17:0]      normal_y_o,
  output logic [1:0]              status_o,
  output logic                    was_flipped_o,
  output logic                    batch_end_o
);

  eoun_pkg::edge_item_t head;
  logic                 head_valid, head_pop;

  eoun_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .on_boundary_i (on_boundary_i),
    .last_edge_i   (last_edge_i),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .tri_a_x_i     (tri_a_x_i),
    .tri_a_y_i     (tri_a_y_i),
    .tri_b_x_i     (tri_b_x_i),
    .tri_b_y_i     (tri_b_y_i),
    .tri_c_x_i     (tri_c_x_i),
    .tri_c_y_i     (tri_c_y_i),
    .head_o        (head),
    .head_valid_o  (head_valid),
    .head_pop_i    (head_pop)
  );

  eoun_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .head_pop_o    (head_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .status_o      (status_o),
    .was_flipped_o (was_flipped_o),
    .batch_end_o   (batch_end_o)
  );

endmodule

`default_nettype wire

>>> sim/edge_outward_unit_normal_test.sv
`timescale 1ns / 1ps

module edge_outward_unit_normal_test;

  localparam int WatchLimit = 5000;
  localparam int NumRandom  = 1330;

  typedef struct {
    logic              on_bnd;
    logic              last;
    logic signed [31:0] x1, y1, x2, y2, ax, ay, bx, by, cx, cy;
  } edge_req_t;

  typedef struct {
    logic [17:0]       nx;
    logic [17:0]       ny;
    eoun_pkg::status_e status;
    logic              flip;
    logic              last;
  } normal_t;

  typedef struct {
    edge_req_t req;
    logic      typed;
    normal_t   res;
  } edge_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  edge_req_t cur = '{default: '0};
  logic signed [17:0] normal_x_o, normal_y_o;
  logic [1:0] status_o;
  logic was_flipped_o, batch_end_o;

  normal_t normal_q[$];
  edge_row_t dir_rows[$];
  int  errors = 0;
  int  idle_cycles = 0;

  edge_outward_unit_normal DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .on_boundary_i(cur.on_bnd), .last_edge_i(cur.last),
    .first_x_i(cur.x1), .first_y_i(cur.y1), .second_x_i(cur.x2), .second_y_i(cur.y2),
    .tri_a_x_i(cur.ax), .tri_a_y_i(cur.ay), .tri_b_x_i(cur.bx), .tri_b_y_i(cur.by),
    .tri_c_x_i(cur.cx), .tri_c_y_i(cur.cy),
    .empty(empty), .pop(pop),
    .normal_x_o(normal_x_o), .normal_y_o(normal_y_o), .status_o(status_o),
    .was_flipped_o(was_flipped_o), .batch_end_o(batch_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Largest q with (2q-1)^2 * s <= a^2 * 2^34: round(a * 2^16 / sqrt(s))
  function automatic logic [16:0] unit_mag(logic [32:0] a, logic [127:0] s);
    logic [127:0] aw, n, m;
    logic [16:0] q, t;
    aw = a;
    n = (aw * aw) << 34;
    q = '0;
    if (a != 0) begin
      for (int b = 16; b >= 0; b--) begin
        t = q | (17'd1 << b);
        m = 2 * t - 1;
        if (m * m * s <= n) q = t;
      end
    end
    return q;
  endfunction

  function automatic normal_t edge_normal(edge_req_t r);
    normal_t o;
    logic signed [79:0] dx, dy, gx, gy, nx, ny, side;
    logic [32:0] adx, ady;
    logic [127:0] s;
    o = '{nx: '0, ny: '0, status: eoun_pkg::StatComputed, flip: 1'b0, last: r.last};
    dx = 80'(r.x2) - 80'(r.x1);
    dy = 80'(r.y2) - 80'(r.y1);
    if (!r.on_bnd) begin
      o.status = eoun_pkg::StatSkipped;
    end else if (dx == 0 && dy == 0) begin
      o.status = eoun_pkg::StatDegenerate;
    end else begin
      adx = dx < 0 ? 33'(-dx) : 33'(dx);
      ady = dy < 0 ? 33'(-dy) : 33'(dy);
      s = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
      nx = 80'(unit_mag(ady, s));
      ny = 80'(unit_mag(adx, s));
      if (dy < 0) nx = -nx;
      if (dx > 0) ny = -ny;
      gx = 80'(r.ax) + 80'(r.bx) + 80'(r.cx) - 3 * 80'(r.x1);
      gy = 80'(r.ay) + 80'(r.by) + 80'(r.cy) - 3 * 80'(r.y1);
      side = gx * dy - gy * dx;
      // Point away from the centroid
      if (side > 0) begin
        nx = -nx;
        ny = -ny;
        o.flip = 1'b1;
      end
      o.nx = nx[17:0];
      o.ny = ny[17:0];
    end
    return o;
  endfunction

  function automatic edge_req_t mk_edge(logic on_bnd, logic last,
      int x1, int y1, int x2, int y2, int ax, int ay, int bx, int by, int cx, int cy);
    edge_req_t r;
    r = '{on_bnd, last, x1, y1, x2, y2, ax, ay, bx, by, cx, cy};
    return r;
  endfunction

  function automatic int rnd_coord(int mode);
    if (mode == 0) return $urandom;
    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  // Mostly real triangles that own the edge, then random wide and odd cases
  function automatic edge_req_t rnd_edge();
    edge_req_t r;
    int kind, mode;
    kind = $urandom_range(0, 99);
    mode = $urandom_range(0, 3) == 0 ? 0 : 1;
    r.on_bnd = kind >= 8;
    r.last = $urandom_range(0, 7) == 0;
    r.x1 = rnd_coord(mode); r.y1 = rnd_coord(mode);
    r.x2 = rnd_coord(mode); r.y2 = rnd_coord(mode);
    r.ax = rnd_coord(mode); r.ay = rnd_coord(mode);
    r.bx = rnd_coord(mode); r.by = rnd_coord(mode);
    r.cx = rnd_coord(mode); r.cy = rnd_coord(mode);
    if (kind < 14) begin
      r.x2 = r.x1; r.y2 = r.y1;
    end else if (kind < 80) begin
      case ($urandom_range(0, 2))
        0: begin r.ax = r.x1; r.ay = r.y1; r.bx = r.x2; r.by = r.y2; end
        1: begin r.bx = r.x1; r.by = r.y1; r.cx = r.x2; r.cy = r.y2; end
        default: begin r.cx = r.x1; r.cy = r.y1; r.ax = r.x2; r.ay = r.y2; end
      endcase
    end else if (kind < 86) begin
      // Axis aligned edge
      if ($urandom_range(0, 1)) r.x2 = r.x1; else r.y2 = r.y1;
    end
    return r;
  endfunction

  // Send one request, holding it until the queue takes it
  task automatic send_edge(edge_req_t r, logic typed, normal_t res);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur <= r;
    push <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    normal_q.push_back(typed ? res : edge_normal(r));
    @(negedge clk_i);
  endtask

  // Drain results with random stalls
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (!empty) break;
      end
    end
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && pop && !empty) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result nx=%h ny=%h st=%0d", $time,
                 normal_x_o, normal_y_o, status_o);
        errors++;
      end else begin
        e = normal_q.pop_front();
        if (normal_x_o !== e.nx || normal_y_o !== e.ny || status_o !== e.status ||
            was_flipped_o !== e.flip || batch_end_o !== e.last) begin
          $display("%0t: expected nx=%h ny=%h st=%0d flip=%b end=%b", $time,
                   e.nx, e.ny, e.status, e.flip, e.last);
          $display("%0t: actual   nx=%h ny=%h st=%0d flip=%b end=%b", $time,
                   normal_x_o, normal_y_o, status_o, was_flipped_o, batch_end_o);
          errors++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL edge_outward_unit_normal");
      $finish;
    end
  end

  initial begin
    normal_t z;
    z = '{nx: '0, ny: '0, status: eoun_pkg::StatComputed, flip: 1'b0, last: 1'b0};
    // Skipped, degenerate, axis edges with and without flip, centroid on the line
    dir_rows.push_back('{mk_edge(0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10), 1,
                         '{'0, '0, eoun_pkg::StatSkipped, 1'b0, 1'b0}});
    dir_rows.push_back('{mk_edge(1, 1, 7, -7, 7, -7, 0, 0, 1, 1, 2, 2), 1,
                         '{'0, '0, eoun_pkg::StatDegenerate, 1'b0, 1'b1}});
    dir_rows.push_back('{mk_edge(1, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 65536), 1,
                         '{18'h0, 18'h30000, eoun_pkg::StatComputed, 1'b0, 1'b0}});
    dir_rows.push_back('{mk_edge(1, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, -65536), 1,
                         '{18'h0, 18'h10000, eoun_pkg::StatComputed, 1'b1, 1'b0}});
    dir_rows.push_back('{mk_edge(1, 1, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 5), 1,
                         '{18'h10000, 18'h0, eoun_pkg::StatComputed, 1'b0, 1'b1}});
    dir_rows.push_back('{mk_edge(1, 0, 0, 0, 1, 1, 0, 0, 1, 1, 5, 0), 0, z});
    dir_rows.push_back('{mk_edge(1, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 0, z});
    dir_rows.push_back('{mk_edge(1, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, z});
    dir_rows.push_back('{mk_edge(1, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 1, -1, -1, -1,
                         -1, -1, -1), 0, z});
    dir_rows.push_back('{mk_edge(1, 0, 0, 0, 1, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0), 0, z});
    dir_rows.push_back('{mk_edge(1, 0, 0, 0, 3, -4, 0, 0, 3, -4, -9, -9), 0, z});
    dir_rows.push_back('{mk_edge(1, 1, 0, 0, 1, 0, -1, 0, 1, 0, 0, 0), 0, z});

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_edge(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    repeat (NumRandom) send_edge(rnd_edge(), 1'b0, z);
    push <= 1'b0;

    wait (normal_q.size() == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS edge_outward_unit_normal");
    end else begin
      $display("FAIL edge_outward_unit_normal");
    end
    $finish;
  end

endmodule
